/* hdl/mrr_pkg.sv */
// Package for the Miller-Rabin round unit: verdict codes and cell control struct.
// No dependencies.
package mrr_pkg;

   typedef enum logic [1:0] {
      VERDICT_TWO       = 2'd0,
      VERDICT_EVEN      = 2'd1,
      VERDICT_COMPOSITE = 2'd2,
      VERDICT_PASSED    = 2'd3
   } verdict_type;

   // control broadcast along the cell row
   typedef struct packed {
      logic start;   // load operands, clear accumulator
      logic step;    // one shift-and-add step
      logic add_en;  // multiplier bit is one
   } cell_ctl_type;

endpackage

/* hdl/miller_rabin_round_unit.sv */
// Miller-Rabin round: one request (candidate, base) gives one verdict.
// Trivial candidates (even, 1 or 2): verdict valid the cycle after the request; others
// run on the serial modular multiplier cell row.
// Throughput: one request at a time; next request taken once the verdict has been accepted.
// Reset: synchronous active-high reset clears the controller and handshakes.
// Depends on mrr_pkg, mrr_mod_mul, mrr_mod_red.
module miller_rabin_round_unit #(
   parameter int WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] candidate, [63:32] base
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [0] probable_prime, [2:1] verdict_kind, rest zero
);
   localparam int EW = $clog2(WIDTH);
   localparam int SW = $clog2(WIDTH + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_RED, S_SQ, S_SQ_W, S_MUL, S_MUL_W, S_NEXT, S_CHK, S_LOOP, S_LOOP_W, S_OUT
   } state_type;

   state_type        state_ff;
   logic [WIDTH-1:0] p_ff, pm1_ff, d_ff, g_ff, x_ff;
   logic [EW-1:0]    bit_ff;
   logic [SW-1:0]    s_ff, i_ff;
   logic             rv_ff, pp_ff;
   mrr_pkg::verdict_type kind_ff;

   logic [63:0]      cand_w, base_w;
   logic [WIDTH-1:0] p_w, a_w, pm1_w, d_w;
   logic [SW-1:0]    s_w;

   always_comb begin
      cand_w = {32'd0, req_tdata[31:0]};
      base_w = {32'd0, req_tdata[63:32]};
      p_w   = cand_w[WIDTH-1:0];
      a_w   = base_w[WIDTH-1:0];
      pm1_w = p_w - 1'b1;
      d_w   = pm1_w;
      s_w   = '0;
      // trailing zero count: largest k with the low k bits clear
      for (int k = 1; k <= WIDTH - 1; k++) begin
         if ((pm1_w & ~({WIDTH{1'b1}} << k)) == '0) begin
            s_w = SW'(k);
            d_w = pm1_w >> k;
         end
      end
   end

   logic             mul_start, mul_done, red_start, red_done;
   logic [WIDTH-1:0] mul_x, mul_y, prod, rem;

   assign mul_x = ((state_ff == S_MUL) || (state_ff == S_MUL_W)) ? g_ff : x_ff;
   assign mul_y = x_ff;
   assign mul_start = (state_ff == S_SQ) || (state_ff == S_MUL) || (state_ff == S_LOOP);

   mrr_mod_mul #(.WIDTH(WIDTH)) u_mul (
      .clock (clock), .reset (reset), .start (mul_start),
      .x (mul_x), .y (mul_y), .n (p_ff), .done (mul_done), .product (prod)
   );

   mrr_mod_red #(.WIDTH(WIDTH)) u_red (
      .clock (clock), .reset (reset), .start (red_start),
      .a (a_w), .n (p_ff), .done (red_done), .rem (rem)
   );

   assign req_tready = (state_ff == S_IDLE) && !rv_ff;
   logic accept;
   assign accept = req_tvalid && req_tready;
   logic nontrivial;
   assign nontrivial = p_w[0] && (p_w != WIDTH'(1));
   assign red_start = accept && nontrivial;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff    <= 1'b0;
      end else begin
         if (rv_ff && rsp_tready) rv_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  p_ff   <= p_w;
                  pm1_ff <= pm1_w;
                  d_ff   <= d_w;
                  s_ff   <= s_w;
                  x_ff   <= WIDTH'(1);
                  bit_ff <= EW'(WIDTH - 1);
                  if (p_w == WIDTH'(2)) begin
                     pp_ff <= 1'b1; kind_ff <= mrr_pkg::VERDICT_TWO; rv_ff <= 1'b1;
                  end else if (!nontrivial) begin
                     pp_ff <= 1'b0; kind_ff <= mrr_pkg::VERDICT_EVEN; rv_ff <= 1'b1;
                  end else begin
                     state_ff <= S_RED;
                  end
               end
            end
            S_RED: if (red_done) begin
               g_ff <= rem;
               state_ff <= S_SQ;
            end
            S_SQ: state_ff <= S_SQ_W;
            S_SQ_W: if (mul_done) begin
               x_ff <= prod;
               state_ff <= d_ff[bit_ff] ? S_MUL : S_NEXT;
            end
            S_MUL: state_ff <= S_MUL_W;
            S_MUL_W: if (mul_done) begin
               x_ff <= prod;
               state_ff <= S_NEXT;
            end
            S_NEXT: begin
               if (bit_ff == '0) begin
                  i_ff <= '0;
                  state_ff <= S_CHK;
               end else begin
                  bit_ff <= bit_ff - 1'b1;
                  state_ff <= S_SQ;
               end
            end
            S_CHK: begin
               if (x_ff == WIDTH'(1) && i_ff == '0) begin
                  pp_ff <= 1'b1; kind_ff <= mrr_pkg::VERDICT_PASSED; state_ff <= S_OUT;
               end else if (i_ff == s_ff) begin
                  pp_ff <= 1'b0; kind_ff <= mrr_pkg::VERDICT_COMPOSITE; state_ff <= S_OUT;
               end else if (x_ff == pm1_ff) begin
                  pp_ff <= 1'b1; kind_ff <= mrr_pkg::VERDICT_PASSED; state_ff <= S_OUT;
               end else begin
                  state_ff <= S_LOOP;
               end
            end
            S_LOOP: state_ff <= S_LOOP_W;
            S_LOOP_W: if (mul_done) begin
               x_ff <= prod;
               i_ff <= i_ff + 1'b1;
               state_ff <= S_CHK;
            end
            S_OUT: if (!rv_ff) begin
               rv_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {5'd0, kind_ff, pp_ff};

   a_pass_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] == (rsp_tdata[2:1] == mrr_pkg::VERDICT_PASSED
                                       || rsp_tdata[2:1] == mrr_pkg::VERDICT_TWO)))
      else $error("verdict bit disagrees with kind");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready)
      else $error("request taken while busy");
   a_red_sync: assert property (@(posedge clock) disable iff (reset)
      red_done |-> (state_ff == S_RED))
      else $error("reduction finished outside its state");
endmodule

/* hdl/mrr_mod_cell.sv */
// One bit slice of the serial modular multiplier: holds one accumulator bit.
// Depends on mrr_pkg.
module mrr_mod_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  mrr_pkg::cell_ctl_type ctl,
   input  logic                  acc_lsb_in,   // neighbor's accumulator bit (shift)
   input  logic                  sel_dbl,      // use doubled value after subtract
   input  logic                  dbl_sub_bit,  // bit of 2*acc - n
   input  logic                  sel_add,
   input  logic                  add_sub_bit,  // bit of t + x - n
   input  logic                  add_raw_bit,  // bit of t + x
   output logic                  acc_bit
);
   logic acc_ff, acc_in;
   logic t_bit;

   always_comb begin
      t_bit = sel_dbl ? dbl_sub_bit : acc_lsb_in;
      acc_in = acc_ff;
      if (ctl.start) begin
         acc_in = 1'b0;
      end else if (ctl.step) begin
         if (ctl.add_en) begin
            acc_in = sel_add ? add_sub_bit : add_raw_bit;
         end else begin
            acc_in = t_bit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign acc_bit = acc_ff;
endmodule

/* hdl/mrr_mod_mul.sv */
// Bit-serial modular multiplier built from a row of mrr_mod_cell slices.
// Depends on mrr_pkg and mrr_mod_cell.
module mrr_mod_mul #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] x,
   input  logic [WIDTH-1:0] y,
   input  logic [WIDTH-1:0] n,
   output logic             done,
   output logic [WIDTH-1:0] product
);
   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] y_ff, y_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WIDTH-1:0] acc;

   logic [WIDTH:0]   dbl, dbl_sub, t, add_raw, add_sub;
   logic             sel_dbl, sel_add;
   logic [WIDTH-1:0] t_w;
   mrr_pkg::cell_ctl_type ctl;

   always_comb begin
      dbl     = {acc, 1'b0};
      dbl_sub = dbl - {1'b0, n};
      sel_dbl = (dbl >= {1'b0, n});
      t       = sel_dbl ? dbl_sub : dbl;
      t_w     = t[WIDTH-1:0];
      add_raw = {1'b0, t_w} + {1'b0, x};
      add_sub = add_raw - {1'b0, n};
      sel_add = (add_raw >= {1'b0, n});
      ctl.start  = start;
      ctl.step   = busy_ff;
      ctl.add_en = y_ff[WIDTH-1];
   end

   for (genvar i = 0; i < WIDTH; i++) begin : g_cell
      mrr_mod_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .acc_lsb_in  (dbl[i]),
         .sel_dbl     (sel_dbl),
         .dbl_sub_bit (dbl_sub[i]),
         .sel_add     (sel_add),
         .add_sub_bit (add_sub[i]),
         .add_raw_bit (add_raw[i]),
         .acc_bit     (acc[i])
      );
   end

   always_comb begin
      y_in    = y_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         y_in    = y;
         cnt_in  = CW'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         y_in   = {y_ff[WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      y_ff <= y_in;
   end

   assign done    = done_ff;
   assign product = acc;
endmodule

/* hdl/mrr_mod_red.sv */
// Bit-serial reduction a mod n (restoring, one bit per cycle).
// No dependencies.
module mrr_mod_red #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] a,
   input  logic [WIDTH-1:0] n,
   output logic             done,
   output logic [WIDTH-1:0] rem
);
   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] a_ff, a_in, r_ff, r_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [WIDTH:0]   sh, sub;

   always_comb begin
      sh      = {r_ff, a_ff[WIDTH-1]};
      sub     = sh - {1'b0, n};
      a_in    = a_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = a;
         r_in    = '0;
         cnt_in  = CW'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         a_in   = {a_ff[WIDTH-2:0], 1'b0};
         r_in   = (sh >= {1'b0, n}) ? sub[WIDTH-1:0] : sh[WIDTH-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff <= a_in;
      r_ff <= r_in;
   end

   assign done = done_ff;
   assign rem  = r_ff;
endmodule
